@@ rtl/mbfr_pkg.sv @@
// Shared constants, request codes and transaction types of the bit-field reader.
// No dependencies; the front end, queue, back end and top level refer to this package by scoped names.
package mbfr_pkg;

  // Size of the byte store and the widest field that one request returns.
  localparam int STORE_BYTES    = 4096;
  localparam int MAX_FIELD_BITS = 32;

  // Fixed widths of the transaction fields.
  localparam int FIELD_W = 32;
  localparam int COUNT_W = 6;

  // The store is split into four byte lanes so that eight consecutive bytes can be read at once.
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int ROW_DEPTH = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W     = $clog2(ROW_DEPTH);

  // Byte counts and indexes reach STORE_BYTES itself; a bit position adds three bits.
  localparam int SB_W  = $clog2(STORE_BYTES + 1);
  localparam int POS_W = SB_W + 3;

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_W     = $clog2(Q_DEPTH);

  // Request codes.
  localparam logic [2:0] REQ_LOAD       = 3'd0;
  localparam logic [2:0] REQ_GET        = 3'd1;
  localparam logic [2:0] REQ_SHOW       = 3'd2;
  localparam logic [2:0] REQ_SKIP       = 3'd3;
  localparam logic [2:0] REQ_ALIGN      = 3'd4;
  localparam logic [2:0] REQ_SHOW_ALIGN = 3'd5;
  localparam logic [2:0] REQ_STUFF      = 3'd6;

  // One classified request, as handed from the front to the back.
  typedef struct packed {
    logic               val_en;
    logic               stuff_chk;
    logic [POS_W-1:0]   pos;
    logic [COUNT_W-1:0] len;
    logic [COUNT_W-1:0] nvalid;
    logic               at_end;
    logic               is_aligned;
    logic [3:0]         bits_to_align;
  } cmd_t;

  // One byte write into the store.
  typedef struct packed {
    logic              we;
    logic [LANE_W-1:0] lane;
    logic [ROW_W-1:0]  row;
    logic [7:0]        data;
  } wr_t;

endpackage

@@ rtl/mbfr_ram.sv @@
// Generic RAM: one write port and two read ports with registered read data.
// No dependencies.
module mbfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports; the data holds while the read enable is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/mbfr_front.sv @@
// Front end: accepts requests, keeps the read position and flags, writes loaded bytes.
// Depends on mbfr_pkg; feeds mbfr_queue with one command per accepted transaction.
module mbfr_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic [7:0]                     in_byte_in,
  input  logic [mbfr_pkg::COUNT_W-1:0]   in_bit_count,
  input  logic                           q_full,
  output logic                           q_push,
  output mbfr_pkg::cmd_t                 q_cmd,
  output mbfr_pkg::wr_t                  wr
);

  localparam int SB_W    = mbfr_pkg::SB_W;
  localparam int POS_W   = mbfr_pkg::POS_W;
  localparam int COUNT_W = mbfr_pkg::COUNT_W;

  logic [SB_W-1:0]    bytes_stored_r, bytes_stored_nxt;
  logic [SB_W-1:0]    rd_byte_r, rd_byte_nxt;
  logic [2:0]         rd_off_r, rd_off_nxt;
  logic               end_r, end_nxt;
  logic               accept;
  logic [POS_W-1:0]   pos, total, apos, rd_pos, avail, pos_adv;
  logic [COUNT_W-1:0] n_sat, rd_len, avail6, nvalid;
  logic               do_rd, short_rd;

  // A transaction is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Current bit position, stored bit count and the next byte boundary.
  assign pos   = {rd_byte_r, rd_off_r};
  assign total = {bytes_stored_r, 3'b000};
  assign apos  = (rd_off_r != 3'd0) ? {rd_byte_r + SB_W'(1), 3'b000} : pos;
  assign n_sat = (in_bit_count > COUNT_W'(mbfr_pkg::MAX_FIELD_BITS))
                 ? COUNT_W'(mbfr_pkg::MAX_FIELD_BITS) : in_bit_count;

  // Where the read starts and how many bits it takes.
  always_comb begin
    do_rd  = 1'b0;
    rd_pos = pos;
    rd_len = '0;
    case (in_req_type)
      mbfr_pkg::REQ_GET, mbfr_pkg::REQ_SHOW, mbfr_pkg::REQ_SKIP: begin
        do_rd  = (n_sat != '0);
        rd_len = n_sat;
      end
      mbfr_pkg::REQ_SHOW_ALIGN: begin
        do_rd  = (n_sat != '0);
        rd_pos = apos;
        rd_len = n_sat;
      end
      mbfr_pkg::REQ_STUFF: begin
        do_rd  = 1'b1;
        rd_len = COUNT_W'(4'd8 - {1'b0, rd_off_r});
      end
      default: begin
        do_rd = 1'b0;
      end
    endcase
  end

  // Bits available from the read start, saturated to the widest field.
  assign avail    = (rd_pos < total) ? (total - rd_pos) : '0;
  assign avail6   = (avail >= POS_W'(mbfr_pkg::MAX_FIELD_BITS))
                    ? COUNT_W'(mbfr_pkg::MAX_FIELD_BITS) : avail[COUNT_W-1:0];
  assign short_rd = do_rd && (rd_len > avail6);
  assign nvalid   = !do_rd ? '0 : (short_rd ? avail6 : rd_len);
  assign pos_adv  = pos + POS_W'(n_sat);

  // Next position, fill count and sticky end flag.
  always_comb begin
    bytes_stored_nxt = bytes_stored_r;
    rd_byte_nxt      = rd_byte_r;
    rd_off_nxt       = rd_off_r;
    end_nxt          = end_r | short_rd;
    wr.we            = 1'b0;
    wr.lane          = bytes_stored_r[mbfr_pkg::LANE_W-1:0];
    wr.row           = bytes_stored_r[mbfr_pkg::ROW_W+1:2];
    wr.data          = in_byte_in;
    case (in_req_type)
      mbfr_pkg::REQ_LOAD: begin
        if (bytes_stored_r < SB_W'(mbfr_pkg::STORE_BYTES)) begin
          wr.we            = accept;
          bytes_stored_nxt = bytes_stored_r + SB_W'(1);
        end
      end
      mbfr_pkg::REQ_GET, mbfr_pkg::REQ_SKIP: begin
        if (do_rd && !short_rd) begin
          rd_byte_nxt = pos_adv[POS_W-1:3];
          rd_off_nxt  = pos_adv[2:0];
        end
      end
      mbfr_pkg::REQ_ALIGN: begin
        if (rd_off_r != 3'd0) begin
          rd_off_nxt  = 3'd0;
          rd_byte_nxt = rd_byte_r + SB_W'(1);
        end
      end
      default: begin
        rd_off_nxt = rd_off_r;
      end
    endcase
  end

  // Command for the back end, with the status after this transaction.
  always_comb begin
    q_cmd.val_en        = do_rd && (in_req_type != mbfr_pkg::REQ_SKIP);
    q_cmd.stuff_chk     = (in_req_type == mbfr_pkg::REQ_STUFF);
    q_cmd.pos           = rd_pos;
    q_cmd.len           = rd_len;
    q_cmd.nvalid        = nvalid;
    q_cmd.at_end        = end_nxt;
    q_cmd.is_aligned    = (rd_off_nxt == 3'd0);
    q_cmd.bits_to_align = 4'd8 - {1'b0, rd_off_nxt};
  end

  // State registers move only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_stored_r <= '0;
      rd_byte_r      <= '0;
      rd_off_r       <= '0;
      end_r          <= 1'b0;
    end else if (accept) begin
      bytes_stored_r <= bytes_stored_nxt;
      rd_byte_r      <= rd_byte_nxt;
      rd_off_r       <= rd_off_nxt;
      end_r          <= end_nxt;
    end
  end

endmodule

@@ rtl/mbfr_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on mbfr_pkg for the command type and depth.
module mbfr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbfr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output mbfr_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);

  localparam int Q_W = mbfr_pkg::Q_W;

  mbfr_pkg::cmd_t  entry_r [mbfr_pkg::Q_DEPTH];
  logic [Q_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_W:0]    count_r, count_nxt;
  logic            do_pop;

  assign full   = (count_r == (Q_W+1)'(mbfr_pkg::Q_DEPTH));
  assign empty  = (count_r == '0);
  assign head   = entry_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  // Occupancy after this cycle's push and pop.
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (Q_W+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (Q_W+1)'(1);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/mbfr_back.sv @@
// Back end: owns the byte store, reads an eight-byte window and extracts the field.
// Depends on mbfr_pkg and mbfr_ram; takes commands from mbfr_queue.
module mbfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mbfr_pkg::wr_t                  wr,
  input  mbfr_pkg::cmd_t                 q_head,
  input  logic                           q_empty,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbfr_pkg::FIELD_W-1:0]   out_field_value,
  output logic [mbfr_pkg::COUNT_W-1:0]   out_bits_valid,
  output logic                           out_at_end,
  output logic                           out_is_aligned,
  output logic [3:0]                     out_bits_to_align,
  output logic                           out_stuffing_ok
);

  localparam int ROW_W   = mbfr_pkg::ROW_W;
  localparam int FIELD_W = mbfr_pkg::FIELD_W;
  localparam int COUNT_W = mbfr_pkg::COUNT_W;

  logic                 s1_valid_r, s2_valid_r, out_valid_r;
  mbfr_pkg::cmd_t       s1_cmd_r, s2_cmd_r;
  logic                 s1_en, s2_en, out_en;
  logic [ROW_W-1:0]     row_a, row_b;
  logic [7:0]           rd_a [mbfr_pkg::LANES];
  logic [7:0]           rd_b [mbfr_pkg::LANES];
  logic [2*FIELD_W-1:0] window, window_sh;
  logic [FIELD_W-1:0]   s2_field_r, masked, value, stuff_pat;
  logic                 stuff_ok;

  // Stage enables: a stage loads when it is empty or its successor moves on.
  assign out_en    = !out_valid_r || !out_stall;
  assign s2_en     = !s2_valid_r || out_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign q_pop     = s1_en;
  assign out_valid = out_valid_r;

  // Rows of the window: the row holding the first byte and the one after it.
  assign row_a = q_head.pos[ROW_W+4:5];
  assign row_b = row_a + ROW_W'(1);

  // One RAM per byte lane, both rows read together.
  for (genvar lane = 0; lane < mbfr_pkg::LANES; lane++) begin : g_lane
    mbfr_ram #(
      .WIDTH (8),
      .DEPTH (mbfr_pkg::ROW_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (wr.we && (wr.lane == mbfr_pkg::LANE_W'(lane))),
      .waddr   (wr.row),
      .wdata   (wr.data),
      .re      (s1_en),
      .raddr_a (row_a),
      .raddr_b (row_b),
      .rdata_a (rd_a[lane]),
      .rdata_b (rd_b[lane])
    );
  end

  // Stage one: command alongside the RAM read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cmd_r <= q_head;
    end
  end

  // Stage two: left-align the field so that its first bit is the most significant.
  assign window    = {rd_a[0], rd_a[1], rd_a[2], rd_a[3], rd_b[0], rd_b[1], rd_b[2], rd_b[3]};
  assign window_sh = window << s1_cmd_r.pos[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_cmd_r   <= s1_cmd_r;
      s2_field_r <= window_sh[2*FIELD_W-1:FIELD_W];
    end
  end

  // Clear the bits past the end of the store, then right-align.
  assign masked    = s2_field_r & ~({FIELD_W{1'b1}} >> s2_cmd_r.nvalid);
  assign value     = s2_cmd_r.val_en ? (masked >> (COUNT_W'(FIELD_W) - s2_cmd_r.len)) : '0;
  assign stuff_pat = ~({FIELD_W{1'b1}} << (s2_cmd_r.len - COUNT_W'(1)));
  assign stuff_ok  = s2_cmd_r.stuff_chk && (s2_cmd_r.nvalid == s2_cmd_r.len)
                     && (value == stuff_pat);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_field_value   <= value;
      out_bits_valid    <= s2_cmd_r.nvalid;
      out_at_end        <= s2_cmd_r.at_end;
      out_is_aligned    <= s2_cmd_r.is_aligned;
      out_bits_to_align <= s2_cmd_r.bits_to_align;
      out_stuffing_ok   <= stuff_ok;
    end
  end

endmodule

@@ rtl/msb_first_bit_field_reader_core.sv @@
// MSB-first bit-field reader: top level joining the front end, command queue and back end.
// A transaction goes through the command queue and the stage-one, stage-two and output registers.
// Throughput: one transaction per cycle unless stalled; the front end keeps the position and
// the back end reads an eight-byte window from four byte-lane RAMs, fully pipelined.
// Reset (synchronous, active low) clears the position, fill count, end flag and pipeline;
// the byte store itself is not cleared and needs no clearing pass.
module msb_first_bit_field_reader_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic [7:0]                     in_byte_in,
  input  logic [mbfr_pkg::COUNT_W-1:0]   in_bit_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mbfr_pkg::FIELD_W-1:0]   out_field_value,
  output logic [mbfr_pkg::COUNT_W-1:0]   out_bits_valid,
  output logic                           out_at_end,
  output logic                           out_is_aligned,
  output logic [3:0]                     out_bits_to_align,
  output logic                           out_stuffing_ok
);

  logic           q_full, q_empty, q_push, q_pop;
  mbfr_pkg::cmd_t q_cmd, q_head;
  mbfr_pkg::wr_t  wr;

  // Front end: classification and position keeping.
  mbfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_byte_in   (in_byte_in),
    .in_bit_count (in_bit_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd),
    .wr           (wr)
  );

  // Command queue between the two halves.
  mbfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: byte store and field extraction.
  mbfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .wr                (wr),
    .q_head            (q_head),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_field_value   (out_field_value),
    .out_bits_valid    (out_bits_valid),
    .out_at_end        (out_at_end),
    .out_is_aligned    (out_is_aligned),
    .out_bits_to_align (out_bits_to_align),
    .out_stuffing_ok   (out_stuffing_ok)
  );

endmodule
